// ----- hw/rtl/amec_pkg.sv -----
// Shared widths, reset values and codes of the motion event classifier.
package amec_pkg;

  localparam int DATA_W        = 10;
  localparam int TILT_THR_W    = 9;
  localparam int SHAKE_THR_W   = 10;
  localparam int CFG_W         = 10;
  localparam int CFG_IDX_W     = 1;
  localparam int AXES_W        = 2;
  localparam int AVG_LEN_DEF   = 8;

  localparam logic [TILT_THR_W-1:0]  TILT_THR_RST  = TILT_THR_W'(100);
  localparam logic [SHAKE_THR_W-1:0] SHAKE_THR_RST = SHAKE_THR_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_THR  = 1'b0,
    CFG_SHAKE_THR = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_TILT       = 3'd1,
    EV_TAP        = 3'd2,
    EV_DOUBLE_TAP = 3'd3,
    EV_SHAKE      = 3'd4
  } event_code_t;

  typedef logic signed [DATA_W-1:0] sample_t;

endpackage

// ----- hw/rtl/amec_in_if.sv -----
// Sample channel: valid/ready handshake with one accelerometer sample and sensor flags.
interface amec_in_if;
  logic                valid;
  logic                ready;
  amec_pkg::sample_t   sample_x;
  amec_pkg::sample_t   sample_y;
  amec_pkg::sample_t   sample_z;
  logic                interrupt_pending;
  logic                tap_flag;
  logic                double_tap_flag;
  logic                activity_flag;
  logic                inactivity_flag;

  modport source (
    output valid, sample_x, sample_y, sample_z, interrupt_pending, tap_flag,
           double_tap_flag, activity_flag, inactivity_flag,
    input  ready
  );

  modport sink (
    input  valid, sample_x, sample_y, sample_z, interrupt_pending, tap_flag,
           double_tap_flag, activity_flag, inactivity_flag,
    output ready
  );
endinterface

// ----- hw/rtl/amec_out_if.sv -----
// Event channel: valid/ready handshake with one classified result.
interface amec_out_if;
  logic                            valid;
  logic                            ready;
  amec_pkg::event_code_t           event_code;
  logic [amec_pkg::AXES_W-1:0]     tilt_axes;
  logic                            is_active;
  amec_pkg::sample_t               filtered_x;
  amec_pkg::sample_t               filtered_y;
  amec_pkg::sample_t               filtered_z;

  modport source (
    output valid, event_code, tilt_axes, is_active, filtered_x, filtered_y, filtered_z,
    input  ready
  );

  modport sink (
    input  valid, event_code, tilt_axes, is_active, filtered_x, filtered_y, filtered_z,
    output ready
  );
endinterface

// ----- hw/rtl/amec_avg_div.sv -----
// Truncating divide of a running sum by the window length via an exact reciprocal multiply.
module amec_avg_div #(
  parameter int AVG_LEN = amec_pkg::AVG_LEN_DEF,
  parameter int SUM_W   = amec_pkg::DATA_W + $clog2(AVG_LEN) + 1
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [SUM_W-1:0]           sum,
  output logic [amec_pkg::DATA_W-1:0]       quot,
  output logic                              neg
);

  localparam int AW     = SUM_W - 1;
  localparam int SHIFT  = amec_pkg::DATA_W + 2 * $clog2(AVG_LEN);
  localparam int RECIP  = ((1 << SHIFT) + AVG_LEN - 1) / AVG_LEN;
  localparam int PW     = AW + SHIFT + 1;

  logic [AW-1:0] mag;
  logic [PW-1:0] prod;

  assign mag  = sum[SUM_W-1] ? AW'(-sum) : AW'(sum);
  assign prod = PW'(mag) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= prod[SHIFT +: amec_pkg::DATA_W];
      neg  <= sum[SUM_W-1];
    end
  end

endmodule

// ----- hw/rtl/accel_motion_event_classifier.sv -----
// Motion event classifier top level: moving-average filter, tilt, tap/shake and activity.
//
// One sample is transferred per cycle; its result passes through stage 1, the running sums,
// the divided averages and the output register before it is presented. The pipeline keeps
// that pace as long as results are taken. The per-axis history lives in one memory of
// AVERAGE_LENGTH entries with one read and one write per sample, and the running sums are
// updated once per sample from the entry that the new sample replaces, so the sample rate
// is bound by that single read-modify-write of the history memory. Entries never written
// since reset read as zero through per-entry valid bits, so no clearing pass is needed and
// samples are taken right after reset.
module accel_motion_event_classifier #(
  parameter int AVERAGE_LENGTH = amec_pkg::AVG_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [amec_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [amec_pkg::CFG_W-1:0]        wr_data,
  amec_in_if.sink                           samples,
  amec_out_if.source                        events
);

  localparam int DW      = amec_pkg::DATA_W;
  localparam int POS_W   = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
  localparam int SUM_W   = DW + $clog2(AVERAGE_LENGTH) + 1;
  localparam int ENTRY_W = 3 * DW;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVERAGE_LENGTH - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(1 << (DW - 1)) * AVERAGE_LENGTH);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(((1 << (DW - 1)) - 1) * AVERAGE_LENGTH);

  logic [amec_pkg::TILT_THR_W-1:0]  tilt_thr;
  logic [amec_pkg::SHAKE_THR_W-1:0] shake_thr;

  logic                  accept, s2_ld, s3_ld, out_ld;
  logic [POS_W-1:0]      ring_pos, pos_next;
  amec_pkg::sample_t     prev_x, prev_y;
  logic                  active, active_next;

  logic signed [DW:0]    diff_x, diff_y;
  logic [DW:0]           dx, dy, thr_ext;
  amec_pkg::event_code_t ev_in;

  logic                  s1_valid, s1_active, s1_fwd, s1_rd_valid;
  logic [POS_W-1:0]      s1_pos;
  amec_pkg::sample_t     s1_x, s1_y, s1_z;
  amec_pkg::event_code_t s1_ev;
  logic [ENTRY_W-1:0]    s1_rd_data, s1_fwd_data, old_entry;
  amec_pkg::sample_t     old_x, old_y, old_z;

  logic [ENTRY_W-1:0]    ring [AVERAGE_LENGTH];
  logic [AVERAGE_LENGTH-1:0] ring_vld;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;

  logic                  s2_valid, s2_active;
  amec_pkg::event_code_t s2_ev;
  logic                  s3_valid, s3_active;
  amec_pkg::event_code_t s3_ev;
  logic [DW-1:0]         q_x, q_y, q_z;
  logic                  neg_x, neg_y, neg_z;

  logic [amec_pkg::AXES_W-1:0] axes;
  amec_pkg::event_code_t       code;

  // Handshake and stage advance
  assign out_ld        = s3_valid && (!events.valid || events.ready);
  assign s3_ld         = s2_valid && (!s3_valid || out_ld);
  assign s2_ld         = s1_valid && (!s2_valid || s3_ld);
  assign samples.ready = !s1_valid || s2_ld;
  assign accept        = samples.valid && samples.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_thr  <= amec_pkg::TILT_THR_RST;
      shake_thr <= amec_pkg::SHAKE_THR_RST;
    end else if (wr_en) begin
      unique case (amec_pkg::cfg_index_t'(wr_index))
        amec_pkg::CFG_TILT_THR:  tilt_thr  <= wr_data[amec_pkg::TILT_THR_W-1:0];
        amec_pkg::CFG_SHAKE_THR: shake_thr <= wr_data[amec_pkg::SHAKE_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Deltas, tap/shake classification and activity at transfer
  assign diff_x  = (DW+1)'(samples.sample_x) - (DW+1)'(prev_x);
  assign diff_y  = (DW+1)'(samples.sample_y) - (DW+1)'(prev_y);
  assign dx      = diff_x[DW] ? (DW+1)'(-diff_x) : (DW+1)'(diff_x);
  assign dy      = diff_y[DW] ? (DW+1)'(-diff_y) : (DW+1)'(diff_y);
  assign thr_ext = (DW+1)'(shake_thr);

  always_comb begin
    ev_in = amec_pkg::EV_NONE;
    if (samples.interrupt_pending) begin
      if (dx < thr_ext && dy < thr_ext) begin
        if (samples.tap_flag) begin
          ev_in = samples.double_tap_flag ? amec_pkg::EV_DOUBLE_TAP : amec_pkg::EV_TAP;
        end
      end else if (dx > thr_ext || dy > thr_ext) begin
        ev_in = amec_pkg::EV_SHAKE;
      end
    end
  end

  assign active_next = samples.interrupt_pending ?
                       ((active || samples.activity_flag) && !samples.inactivity_flag) :
                       active;
  assign pos_next    = (ring_pos == POS_LAST) ? '0 : ring_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      active   <= 1'b0;
    end else if (accept) begin
      ring_pos <= pos_next;
      prev_x   <= samples.sample_x;
      prev_y   <= samples.sample_y;
      active   <= active_next;
    end
  end

  // History memory: read the entry being replaced, write back one stage later
  always_ff @(posedge clk) begin
    if (s2_ld) begin
      ring[s1_pos] <= {s1_z, s1_y, s1_x};
    end
    if (accept) begin
      s1_rd_data <= ring[pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
    end else if (s2_ld) begin
      ring_vld[s1_pos] <= 1'b1;
    end
  end

  // Stage 1: sample registered, old entry arriving from memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s2_ld) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos      <= pos_next;
      s1_x        <= samples.sample_x;
      s1_y        <= samples.sample_y;
      s1_z        <= samples.sample_z;
      s1_ev       <= ev_in;
      s1_active   <= active_next;
      s1_rd_valid <= ring_vld[pos_next];
      s1_fwd      <= s2_ld && (s1_pos == pos_next);
      s1_fwd_data <= {s1_z, s1_y, s1_x};
    end
  end

  assign old_entry = s1_fwd ? s1_fwd_data : (s1_rd_valid ? s1_rd_data : '0);
  assign old_x     = old_entry[0*DW +: DW];
  assign old_y     = old_entry[1*DW +: DW];
  assign old_z     = old_entry[2*DW +: DW];

  assign sum_x_next = sum_x + SUM_W'(s1_x) - SUM_W'(old_x);
  assign sum_y_next = sum_y + SUM_W'(s1_y) - SUM_W'(old_y);
  assign sum_z_next = sum_z + SUM_W'(s1_z) - SUM_W'(old_z);

  // Stage 2: running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x    <= '0;
      sum_y    <= '0;
      sum_z    <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s2_ld) begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        sum_z <= sum_z_next;
      end
      if (s2_ld) begin
        s2_valid <= 1'b1;
      end else if (s3_ld) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_ev     <= s1_ev;
      s2_active <= s1_active;
    end
  end

  // Stage 3: divided averages
  amec_avg_div #(.AVG_LEN(AVERAGE_LENGTH), .SUM_W(SUM_W)) u_div_x (
    .clk(clk), .en(s3_ld), .sum(sum_x), .quot(q_x), .neg(neg_x)
  );
  amec_avg_div #(.AVG_LEN(AVERAGE_LENGTH), .SUM_W(SUM_W)) u_div_y (
    .clk(clk), .en(s3_ld), .sum(sum_y), .quot(q_y), .neg(neg_y)
  );
  amec_avg_div #(.AVG_LEN(AVERAGE_LENGTH), .SUM_W(SUM_W)) u_div_z (
    .clk(clk), .en(s3_ld), .sum(sum_z), .quot(q_z), .neg(neg_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ld) begin
      s3_valid <= 1'b1;
    end else if (out_ld) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_ev     <= s2_ev;
      s3_active <= s2_active;
    end
  end

  // Output register: tilt and final event code
  assign axes[0] = q_x > DW'(tilt_thr);
  assign axes[1] = q_y > DW'(tilt_thr);
  assign code    = (s3_ev != amec_pkg::EV_NONE) ? s3_ev :
                   ((axes != '0) ? amec_pkg::EV_TILT : amec_pkg::EV_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (out_ld) begin
      events.valid <= 1'b1;
    end else if (events.ready) begin
      events.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      events.event_code <= code;
      events.tilt_axes  <= axes;
      events.is_active  <= s3_active;
      events.filtered_x <= neg_x ? DW'(-q_x) : q_x;
      events.filtered_y <= neg_y ? DW'(-q_y) : q_y;
      events.filtered_z <= neg_z ? DW'(-q_z) : q_z;
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    sum_x >= SUM_MIN && sum_x <= SUM_MAX)
    else $error("running X sum out of window range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_pos <= POS_LAST)
    else $error("ring position past window end");

  a_tilt_code: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.tilt_axes != '0 |-> events.event_code != amec_pkg::EV_NONE)
    else $error("tilted axes reported without an event");

  a_inactive: assert property (@(posedge clk) disable iff (rst)
    accept && samples.interrupt_pending && samples.inactivity_flag |=> !active)
    else $error("inactivity did not clear active state");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for accel_motion_event_classifier with stalls and config phases.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD   = 2;
  localparam int RING_LEN      = amec_pkg::AVG_LEN_DEF;
  localparam int PHASE_ITEMS   = 215;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SHOWN_ERRORS  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT       = 500;

  typedef struct {
    amec_pkg::sample_t x;
    amec_pkg::sample_t y;
    amec_pkg::sample_t z;
    logic    irq;
    logic    tap;
    logic    dtap;
    logic    act;
    logic    inact;
  } sample_item_t;

  typedef struct {
    amec_pkg::event_code_t code;
    logic [amec_pkg::AXES_W-1:0] axes;
    logic    active;
    amec_pkg::sample_t fx;
    amec_pkg::sample_t fy;
    amec_pkg::sample_t fz;
  } event_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [amec_pkg::CFG_IDX_W-1:0] wr_index = amec_pkg::CFG_TILT_THR;
  logic [amec_pkg::CFG_W-1:0] wr_data = '0;

  amec_in_if  sample_ch ();
  amec_out_if event_ch ();

  accel_motion_event_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (sample_ch.sink),
    .events   (event_ch.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor state
  int tilt_limit  = int'(amec_pkg::TILT_THR_RST);
  int shake_limit = int'(amec_pkg::SHAKE_THR_RST);
  int last_x, last_y;
  int ring [3][RING_LEN];
  int ring_pos;
  logic motion_active;

  sample_item_t  sample_queue [$];
  event_result_t expected_events [$];
  sample_item_t  offered;

  int gen_prev_x, gen_prev_y;
  int accepted, checked, mismatches, cycle_count, settings_used;
  int code_hits [5];
  int gap_left, burst_left;
  int stall_mode, stall_left;
  bit long_hold;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic event_result_t classify_sample(input sample_item_t s);
    event_result_t r;
    int nx, ny, nz, dx, dy;
    int sum [3];
    int avg [3];
    logic [amec_pkg::AXES_W-1:0] axes;
    amec_pkg::event_code_t code;
    nx = int'(s.x);
    ny = int'(s.y);
    nz = int'(s.z);
    dx = magnitude(nx - last_x);
    dy = magnitude(ny - last_y);
    last_x = nx;
    last_y = ny;
    ring_pos = (ring_pos + 1 >= RING_LEN) ? 0 : ring_pos + 1;
    ring[0][ring_pos] = nx;
    ring[1][ring_pos] = ny;
    ring[2][ring_pos] = nz;
    for (int a = 0; a < 3; a++) begin
      sum[a] = 0;
      for (int i = 0; i < RING_LEN; i++) sum[a] += ring[a][i];
      avg[a] = sum[a] / RING_LEN;
    end
    axes = '0;
    if (magnitude(avg[0]) > tilt_limit) axes[0] = 1'b1;
    if (magnitude(avg[1]) > tilt_limit) axes[1] = 1'b1;
    code = (axes != '0) ? amec_pkg::EV_TILT : amec_pkg::EV_NONE;
    if (s.irq) begin
      if (dx < shake_limit && dy < shake_limit) begin
        if (s.tap) code = s.dtap ? amec_pkg::EV_DOUBLE_TAP : amec_pkg::EV_TAP;
      end else if (dx > shake_limit || dy > shake_limit) begin
        code = amec_pkg::EV_SHAKE;
      end
      if (s.act) motion_active = 1'b1;
      if (s.inact) motion_active = 1'b0;
    end
    r.code   = code;
    r.axes   = axes;
    r.active = motion_active;
    r.fx     = amec_pkg::sample_t'(avg[0]);
    r.fy     = amec_pkg::sample_t'(avg[1]);
    r.fz     = amec_pkg::sample_t'(avg[2]);
    return r;
  endfunction

  task automatic add_sample(input int x, input int y, input int z, input logic irq,
                            input logic tap, input logic dtap, input logic act,
                            input logic inact);
    sample_item_t s;
    s.x = amec_pkg::sample_t'(x);
    s.y = amec_pkg::sample_t'(y);
    s.z = amec_pkg::sample_t'(z);
    s.irq = irq;
    s.tap = tap;
    s.dtap = dtap;
    s.act = act;
    s.inact = inact;
    gen_prev_x = x;
    gen_prev_y = y;
    sample_queue.push_back(s);
  endtask

  // step away from the previous value by a delta aimed at the tap, bound or shake zone, or jump to a random value
  function automatic int next_axis(input int prev, input int thr);
    int d, v;
    case ($urandom % 10)
      0, 1, 2, 3: d = (thr > 1) ? $urandom_range(thr - 1) : 0;
      4, 5, 6:    d = thr + 1 + $urandom_range(300);
      7:          d = thr;
      default:    return int'($urandom_range(1023)) - 512;
    endcase
    v = ($urandom % 2) ? prev + d : prev - d;
    if (v > 511 || v < -512) v = (v > prev) ? prev - d : prev + d;
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return v;
  endfunction

  task automatic add_random_samples(input int count);
    int z;
    for (int n = 0; n < count; n++) begin
      z = ($urandom % 4 == 0) ? (($urandom % 2) ? 511 : -512)
                              : int'($urandom_range(1023)) - 512;
      add_sample(next_axis(gen_prev_x, shake_limit), next_axis(gen_prev_y, shake_limit), z,
                 ($urandom % 10) < 7, 1'($urandom % 2), 1'($urandom % 2),
                 ($urandom % 5) == 0, ($urandom % 5) == 0);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || sample_ch.valid || expected_events.size() != 0);
  endtask

  task automatic write_register(input amec_pkg::cfg_index_t idx, input int value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= amec_pkg::CFG_W'(value);
    @(posedge clk);
    wr_en    <= 1'b0;
    if (idx == amec_pkg::CFG_TILT_THR) tilt_limit = value & 'h1FF;
    else shake_limit = value & 'h3FF;
  endtask

  task automatic set_thresholds(input int tilt, input int shake);
    write_register(amec_pkg::CFG_TILT_THR, tilt);
    write_register(amec_pkg::CFG_SHAKE_THR, shake);
    settings_used++;
  endtask

  task automatic check_result(input event_result_t got);
    event_result_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("ERROR: result with no pending sample: code=%0d fx=%0d", got.code, got.fx);
      return;
    end
    want = expected_events.pop_front();
    checked++;
    code_hits[want.code]++;
    if (got.code !== want.code || got.axes !== want.axes || got.active !== want.active ||
        got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
        $display("ERROR: result %0d exp code=%0d axes=%0d act=%0d f=%0d/%0d/%0d,",
                 checked, want.code, want.axes, want.active, want.fx, want.fy, want.fz);
        $display("       got code=%0d axes=%0d act=%0d f=%0d/%0d/%0d",
                 got.code, got.axes, got.active, got.fx, got.fy, got.fz);
      end
    end
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_events.push_back(classify_sample(offered));
        accepted++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left > 0 || sample_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          sample_ch.valid <= 1'b0;
        end else begin
          offered = sample_queue.pop_front();
          sample_ch.sample_x          <= offered.x;
          sample_ch.sample_y          <= offered.y;
          sample_ch.sample_z          <= offered.z;
          sample_ch.interrupt_pending <= offered.irq;
          sample_ch.tap_flag          <= offered.tap;
          sample_ch.double_tap_flag   <= offered.dtap;
          sample_ch.activity_flag     <= offered.act;
          sample_ch.inactivity_flag   <= offered.inact;
          sample_ch.valid             <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(60);
            gap_left   = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: take and check results, stall on a changing pattern
  always @(posedge clk) begin
    event_result_t got;
    logic take;
    if (rst) begin
      event_ch.ready <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        got.code   = event_ch.event_code;
        got.axes   = event_ch.tilt_axes;
        got.active = event_ch.is_active;
        got.fx     = event_ch.filtered_x;
        got.fy     = event_ch.filtered_y;
        got.fz     = event_ch.filtered_z;
        check_result(got);
      end
      if (stall_left == 0) begin
        stall_mode = $urandom % 4;
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       take = 1'b1;
        1:       take = 1'($urandom % 2);
        2:       take = ($urandom % 4) == 0;
        default: take = ($urandom % 8) != 0;
      endcase
      event_ch.ready <= take && !long_hold;
    end
  end

  // hold off the receiver long enough for the block to back up
  initial begin
    wait (accepted >= HOLD_AT);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results pending", cycle_count,
             expected_events.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sample_ch.valid             = 1'b0;
    sample_ch.sample_x          = '0;
    sample_ch.sample_y          = '0;
    sample_ch.sample_z          = '0;
    sample_ch.interrupt_pending = 1'b0;
    sample_ch.tap_flag          = 1'b0;
    sample_ch.double_tap_flag   = 1'b0;
    sample_ch.activity_flag     = 1'b0;
    sample_ch.inactivity_flag   = 1'b0;
    event_ch.ready              = 1'b0;
    last_x = 0;
    last_y = 0;
    ring_pos = 0;
    motion_active = 1'b0;
    foreach (ring[a, i]) ring[a][i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    settings_used = 1;
    add_sample(0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    add_sample(0, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(200, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(200, -200, 0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    add_sample(-512, -200, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(511, 511, 511, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    add_sample(511, -512, -512, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (7) add_sample(511, -512, -512, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(511, -512, -512, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(511, -512, -512, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    add_sample(-512, 511, 511, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(-1, -1, -1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    add_random_samples(PHASE_ITEMS);
    wait_drained();

    set_thresholds(0, 0);
    add_random_samples(PHASE_ITEMS);
    wait_drained();
    set_thresholds(511, 1023);
    add_random_samples(PHASE_ITEMS);
    wait_drained();
    set_thresholds($urandom_range(511), $urandom_range(1023));
    add_random_samples(PHASE_ITEMS);
    wait_drained();
    set_thresholds(1, 1);
    add_random_samples(PHASE_ITEMS);
    wait_drained();
    set_thresholds($urandom_range(40, 300), $urandom_range(20, 600));
    add_random_samples(PHASE_ITEMS);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results over %0d threshold settings", checked, settings_used);
    $display("Events none/tilt/tap/double/shake: %0d/%0d/%0d/%0d/%0d",
             code_hits[amec_pkg::EV_NONE], code_hits[amec_pkg::EV_TILT],
             code_hits[amec_pkg::EV_TAP], code_hits[amec_pkg::EV_DOUBLE_TAP],
             code_hits[amec_pkg::EV_SHAKE]);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- accel_motion_event_classifier.f -----
hw/rtl/amec_pkg.sv
hw/rtl/amec_in_if.sv
hw/rtl/amec_out_if.sv
hw/rtl/amec_avg_div.sv
hw/rtl/accel_motion_event_classifier.sv
tb/sv/tb_top.sv
